/* sv/acac_pkg.sv */
// acac_pkg: shared constants for the argb channel arithmetic clamp block
// operation codes, register indexes, field widths and pipeline latency
// no dependencies
package acac_pkg;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int CHAN_W            = 8;
    localparam int OPERAND_W         = 17;
    localparam int MODE_W            = 3;
    localparam int INDEX_W           = 3;
    localparam int LATENCY           = 7;

    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd3;

    localparam logic [INDEX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ALPHA = 3'd1;
    localparam logic [INDEX_W-1:0] REG_RED   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_GREEN = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BLUE  = 3'd4;
endpackage

/* sv/acac_chan.sv */
// acac_chan: one channel of the arithmetic clamp pipeline
// operand register, multiply/add stage, four two-bit divider stages, output clamp
// depends on acac_pkg
module acac_chan
    import acac_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic [MODE_W-1:0]        mode,
    input  logic [CHAN_W-1:0]        x,
    input  logic signed [OPERAND_W:0] operand,
    output logic [CHAN_W-1:0]        y
);
    localparam int DW = CHAN_W + FRACTION_BITS;        // scaled pixel
    localparam int CW = OPERAND_W + 1;                 // operand incl. forced 1.0
    localparam int VW = DW + CW + 1;                   // raw arithmetic result
    localparam int RW = DW + CW;                       // divider working width
    localparam int NS = 4;                             // divider stages

    // stage 0
    logic [CHAN_W-1:0]        x0_reg;
    logic signed [CW-1:0]     c0_reg;
    // stages 1..5
    logic [CHAN_W-1:0]        x_reg   [1:NS+1];
    logic signed [VW-1:0]     raw_reg [1:NS+1];
    logic [RW-1:0]            rem_reg [1:NS+1];
    logic [CHAN_W-1:0]        q_reg   [1:NS+1];
    logic [RW-1:0]            cd_reg  [1:NS+1];
    logic                     zero_reg[1:NS+1];
    logic                     sat_reg [1:NS+1];
    logic [CHAN_W-1:0]        y_reg;

    logic signed [VW-1:0]     raw_next;
    logic [RW-1:0]            dvd;
    logic [RW-1:0]            cpos;
    logic [CHAN_W-1:0]        y_next;
    logic [FRACTION_BITS+CHAN_W:0] scaled_int;

    always_comb
    begin
        dvd  = RW'(x0_reg) << FRACTION_BITS;
        cpos = RW'($unsigned(c0_reg));
        case (mode)
            MODE_ADD: raw_next = VW'(signed'({1'b0, dvd[DW-1:0]})) + VW'(c0_reg);
            MODE_SUB: raw_next = VW'(signed'({1'b0, dvd[DW-1:0]})) - VW'(c0_reg);
            MODE_MUL: raw_next = VW'(signed'({1'b0, x0_reg})) * VW'(c0_reg);
            default:  raw_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x;
        c0_reg <= operand;
        x_reg[1]    <= x0_reg;
        raw_reg[1]  <= raw_next;
        rem_reg[1]  <= dvd;
        q_reg[1]    <= '0;
        cd_reg[1]   <= cpos;
        zero_reg[1] <= (c0_reg <= 0) || (x0_reg == '0);
        sat_reg[1]  <= dvd >= (cpos << CHAN_W);
        for (int s = 1; s <= NS; s++)
        begin
            logic [RW-1:0]     r;
            logic [CHAN_W-1:0] q;
            int                b;
            r = rem_reg[s];
            q = q_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                b = CHAN_W - 1 - 2 * (s - 1) - k;
                if (r >= (cd_reg[s] << b))
                begin
                    r    = r - (cd_reg[s] << b);
                    q[b] = 1'b1;
                end
            end
            rem_reg[s+1]  <= r;
            q_reg[s+1]    <= q;
            x_reg[s+1]    <= x_reg[s];
            raw_reg[s+1]  <= raw_reg[s];
            cd_reg[s+1]   <= cd_reg[s];
            zero_reg[s+1] <= zero_reg[s];
            sat_reg[s+1]  <= sat_reg[s];
        end
        y_reg <= y_next;
    end

    // truncate toward zero then saturate; divide takes the saturated quotient, unused modes pass x through
    always_comb
    begin
        scaled_int = raw_reg[NS+1][FRACTION_BITS+CHAN_W+FRACTION_BITS:FRACTION_BITS];
        case (mode)
            MODE_ADD, MODE_SUB, MODE_MUL:
            begin
                if (raw_reg[NS+1] <= 0)
                    y_next = '0;
                else if ((raw_reg[NS+1] >>> FRACTION_BITS) > VW'(255))
                    y_next = 8'hFF;
                else
                    y_next = scaled_int[CHAN_W-1:0];
            end
            MODE_DIV:
            begin
                if (zero_reg[NS+1])
                    y_next = '0;
                else if (sat_reg[NS+1])
                    y_next = 8'hFF;
                else
                    y_next = q_reg[NS+1];
            end
            default: y_next = x_reg[NS+1];
        endcase
    end

    assign y = y_reg;
endmodule

/* sv/argb_channel_arithmetic_clamp_core.sv */
// argb_channel_arithmetic_clamp_core: top level of the pixel arithmetic clamp block
// config registers, valid pipeline, four channel pipelines
// depends on acac_pkg and acac_chan
//
// takes one argb pixel per clock and gives one pixel per clock; busy never
// rises, so start may be held high every cycle. each pixel passes through the
// operand register, the multiply/add stage, the four two-bit stages of the
// restoring divider and the output register. done marks each result for
// exactly one cycle and the receiver cannot stall, so results must be taken
// as they appear. configuration registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no transaction is in
// flight; writes to unused indexes are ignored. in divide mode a zero operand
// on any channel forces all four operands to 1.0, so the pixel passes through.
module argb_channel_arithmetic_clamp_core
    import acac_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic                 cfg_we,
    input  logic [INDEX_W-1:0]   cfg_index,
    input  logic [OPERAND_W-1:0] cfg_data,
    input  logic [CHAN_W-1:0]    alpha_in,
    input  logic [CHAN_W-1:0]    red_in,
    input  logic [CHAN_W-1:0]    green_in,
    input  logic [CHAN_W-1:0]    blue_in,
    output logic [CHAN_W-1:0]    alpha_out,
    output logic [CHAN_W-1:0]    red_out,
    output logic [CHAN_W-1:0]    green_out,
    output logic [CHAN_W-1:0]    blue_out
);
    logic [MODE_W-1:0]          mode_reg;
    logic signed [OPERAND_W-1:0] op_reg [0:3];
    logic signed [OPERAND_W:0]  op_eff [0:3];
    logic [LATENCY-1:0]         vld_reg;
    logic                       div_fix;
    logic [CHAN_W-1:0]          pix_in  [0:3];
    logic [CHAN_W-1:0]          pix_out [0:3];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ADD;
            for (int i = 0; i < 4; i++)
                op_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                REG_ALPHA: op_reg[0] <= cfg_data;
                REG_RED:   op_reg[1] <= cfg_data;
                REG_GREEN: op_reg[2] <= cfg_data;
                REG_BLUE:  op_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // divide by zero on any channel turns every operand into 1.0
    assign div_fix = (mode_reg == MODE_DIV) &&
                     (op_reg[0] == '0 || op_reg[1] == '0 ||
                      op_reg[2] == '0 || op_reg[3] == '0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            op_eff[i] = div_fix ? (OPERAND_W+1)'(1) <<< FRACTION_BITS
                                : (OPERAND_W+1)'(op_reg[i]);
    end

    // valid bits travel alongside the channel data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
    end

    assign busy = 1'b0;
    assign done = vld_reg[LATENCY-1];

    assign pix_in[0] = alpha_in;
    assign pix_in[1] = red_in;
    assign pix_in[2] = green_in;
    assign pix_in[3] = blue_in;

    for (genvar g = 0; g < 4; g++)
    begin : g_chan
        acac_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan
        (
            .clk     (clk),
            .mode    (mode_reg),
            .x       (pix_in[g]),
            .operand (op_eff[g]),
            .y       (pix_out[g])
        );
    end

    assign alpha_out = pix_out[0];
    assign red_out   = pix_out[1];
    assign green_out = pix_out[2];
    assign blue_out  = pix_out[3];

    // every accepted transaction produces a done strobe
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LATENCY) done)
        else $error("accepted transaction produced no result");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching transaction");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result strobe straight after reset");
endmodule
